// ===== rtl/aamp_pkg.sv =====
package aamp_pkg;

    localparam int DEF_FRAME_BYTES = 64;
    localparam int DEF_CHANNELS    = 8;
    localparam int HDR_BYTES       = 5;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXEMPT_MASK = 8'd1;

    localparam logic [7:0] RST_STALL_LIMIT = 8'd10;
    localparam logic [7:0] RST_EXEMPT_MASK = 8'd0;

    localparam logic [7:0] HDR_SYNC0 = 8'd31;
    localparam logic [7:0] HDR_SYNC1 = 8'd97;
    localparam logic [7:0] HDR_SYNC2 = 8'd52;
    localparam logic [7:0] HDR_SYNC3 = 8'd73;

    localparam logic signed [11:0] GAIN_NUM  = 12'sd1229;
    localparam logic signed [17:0] DC_OFFSET = 18'sd32768;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ALERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_POLL,
        ST_HDR,
        ST_RD,
        ST_PAY
    } t_state;

    typedef struct packed {
        logic take;
        logic store;
        logic cnt_clr;
        logic cnt_inc;
        logic ld_hdr;
        logic ld_pay;
        logic ld_alert;
        logic rd_en;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_sample;
        logic in_ch_ok;
        logic full;
        logic stall;
        logic out_free;
        logic hdr_done;
        logic pay_done;
    } t_sts;

    // header byte at position k; position four carries channel+1
    function automatic logic [7:0] hdr_byte(input logic [2:0] k, input logic [2:0] ch);
        logic [7:0] b;
        case (k)
            3'd0:    b = HDR_SYNC0;
            3'd1:    b = HDR_SYNC1;
            3'd2:    b = HDR_SYNC2;
            3'd3:    b = HDR_SYNC3;
            default: b = {5'd0, ch} + 8'd1;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/aamp_if.sv =====
interface aamp_smp_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [2:0]         channel;
    logic signed [15:0] sample;
    logic [31:0]        now_seconds;

    modport source(output valid, action, channel, sample, now_seconds, input ready);
    modport sink(input valid, action, channel, sample, now_seconds, output ready);
endinterface

interface aamp_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [2:0] stall_channel;

    modport source(output valid, kind, frame_byte, last_byte, stall_channel, input ready);
    modport sink(input valid, kind, frame_byte, last_byte, stall_channel, output ready);
endinterface

interface aamp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/audio_sample_am_packetizer_core.sv =====
// Flow: a sample item passes through IDLE (capture with product) and STORE (convert and store).
// A poll item passes through IDLE and POLL; its alert enters the output register in POLL.
// A full payload then emits FRAME_BYTES bytes: each header byte from state HDR and each
// payload byte through RD and PAY, set by the registered read of the shared payload RAM.
// Reset (synchronous, active low) clears fill counts, last sample times, the output valid
// flag and the controller; the stall limit returns to 10 and the exempt mask to 0.
module audio_sample_am_packetizer_core
    import aamp_pkg::*;
#(
    parameter int FRAME_BYTES = DEF_FRAME_BYTES,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aamp_smp_if.sink   i_smp,
    aamp_res_if.source o_res,
    aamp_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;

    aamp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    aamp_dpath #(
        .FRAME_BYTES(FRAME_BYTES),
        .CHANNELS   (CHANNELS)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (i_smp),
        .o_res  (o_res),
        .i_cfg  (i_cfg),
        .i_cmd  (cmd),
        .o_sts  (sts)
    );

endmodule

// ===== rtl/aamp_ram.sv =====
module aamp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 472,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/aamp_ctrl.sv =====
module aamp_ctrl
    import aamp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take = 1'b1;
                // drop items for channels beyond the configured count
                if (i_sts.in_valid && i_sts.in_ch_ok) begin
                    n_state = i_sts.in_sample ? ST_STORE : ST_POLL;
                end
            end
            ST_STORE: begin
                o_cmd.store   = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state       = i_sts.full ? ST_HDR : ST_IDLE;
            end
            ST_POLL: begin
                if (!i_sts.stall) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.ld_alert = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_hdr = 1'b1;
                    if (i_sts.hdr_done) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_RD;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_PAY;
            end
            ST_PAY: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_pay = 1'b1;
                    if (i_sts.pay_done) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/aamp_dpath.sv =====
module aamp_dpath
    import aamp_pkg::*;
#(
    parameter int FRAME_BYTES = DEF_FRAME_BYTES,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aamp_smp_if.sink    i_smp,
    aamp_res_if.source  o_res,
    aamp_cfg_if.sink    i_cfg,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);

    localparam int PAY_LEN  = FRAME_BYTES - HDR_BYTES;
    localparam int DEPTH    = CHANNELS * PAY_LEN;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(FRAME_BYTES);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic [7:0] r_stall_limit;
    logic [7:0] r_exempt;

    // per-channel state
    logic [CNT_W-1:0] r_fill [CHANNELS];
    logic [31:0]      r_last_seen [CHANNELS];

    // captured item
    logic [2:0]         r_ch;
    logic [31:0]        r_now;
    logic signed [26:0] r_prod;

    logic [CNT_W-1:0] r_cnt;

    // output register
    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic [2:0] r_sch;

    logic                take_xfer;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [CNT_W-1:0]    fill_cur;
    logic [CNT_W-1:0]    fill_inc;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;
    logic signed [16:0]  q;
    logic signed [17:0]  t;
    logic [9:0]          b;
    logic [7:0]          conv_byte;
    logic [31:0]         last_seen;
    logic [31:0]         elapsed;
    logic [7:0]          rdata;
    logic                out_free;

    assign take_xfer   = i_cmd.take && i_smp.valid;
    assign i_smp.ready = i_cmd.take;
    assign i_cfg.ready = 1'b1;

    assign ch_idx = r_ch[CH_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_limit <= RST_STALL_LIMIT;
            r_exempt      <= RST_EXEMPT_MASK;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STALL_LIMIT: r_stall_limit <= i_cfg.data;
                REG_EXEMPT_MASK: r_exempt      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_xfer) begin
            r_ch   <= i_smp.channel;
            r_now  <= i_smp.now_seconds;
            r_prod <= 27'(i_smp.sample) * 27'(GAIN_NUM);
        end
    end

    // sample to byte: floor(v/1024) + 32768, floor by 256, clamp to a byte
    assign q = r_prod[26:10];
    assign t = {q[16], q} + DC_OFFSET;
    assign b = t[17:8];

    always_comb begin
        if (b[9]) begin
            conv_byte = 8'd0;
        end else if (b[8]) begin
            conv_byte = 8'hFF;
        end else begin
            conv_byte = b[7:0];
        end
    end

    assign fill_cur = (r_fill[ch_idx] >= CNT_W'(PAY_LEN)) ? '0 : r_fill[ch_idx];
    assign fill_inc = fill_cur + CNT_W'(1);
    assign base     = ADDR_W'(int'(r_ch) * PAY_LEN);
    assign waddr    = base + ADDR_W'(fill_cur);
    assign raddr    = base + ADDR_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c]      <= '0;
                r_last_seen[c] <= '0;
            end
        end else if (i_cmd.store) begin
            r_fill[ch_idx]      <= (fill_inc == CNT_W'(PAY_LEN)) ? '0 : fill_inc;
            r_last_seen[ch_idx] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    aamp_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_payload (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store),
        .i_waddr(waddr),
        .i_wdata(conv_byte),
        .i_re   (i_cmd.rd_en),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // a timestamp behind the last sample time counts as no time elapsed
    assign last_seen = r_last_seen[ch_idx];
    assign elapsed   = r_now - last_seen;

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_hdr || i_cmd.ld_pay || i_cmd.ld_alert) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_hdr) begin
            r_kind <= KIND_BYTE;
            r_byte <= hdr_byte(r_cnt[2:0], r_ch);
            r_last <= 1'b0;
            r_sch  <= 3'd0;
        end else if (i_cmd.ld_pay) begin
            r_kind <= KIND_BYTE;
            r_byte <= rdata;
            r_last <= (r_cnt == CNT_W'(PAY_LEN - 1));
            r_sch  <= 3'd0;
        end else if (i_cmd.ld_alert) begin
            r_kind <= KIND_ALERT;
            r_byte <= 8'd0;
            r_last <= 1'b0;
            r_sch  <= r_ch;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_kind;
    assign o_res.frame_byte    = r_byte;
    assign o_res.last_byte     = r_last;
    assign o_res.stall_channel = r_sch;

    always_comb begin
        o_sts           = '0;
        o_sts.in_valid  = i_smp.valid;
        o_sts.in_sample = !i_smp.action;
        o_sts.in_ch_ok  = int'(i_smp.channel) < CHANNELS;
        o_sts.full      = (fill_inc == CNT_W'(PAY_LEN));
        o_sts.stall     = !r_exempt[r_ch] && (r_now > last_seen)
                          && (elapsed > {24'd0, r_stall_limit});
        o_sts.out_free  = out_free;
        o_sts.hdr_done  = (r_cnt == CNT_W'(HDR_BYTES - 1));
        o_sts.pay_done  = (r_cnt == CNT_W'(PAY_LEN - 1));
    end

endmodule

// ===== dv/aamp_tb_pkg.sv =====
package aamp_tb_pkg;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_POLL   = 1'b1
    } t_action;

endpackage

// ===== dv/aamp_frame_checker.sv =====
module aamp_frame_checker
    import aamp_pkg::*;
    import aamp_tb_pkg::*;
#(
    parameter int FRAME_BYTES = DEF_FRAME_BYTES,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aamp_smp_if  i_smp,
    aamp_res_if  i_res,
    aamp_cfg_if  i_cfg,
    output int   o_err_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAY_LEN    = FRAME_BYTES - HDR_BYTES;
    localparam int GAIN       = 1229;
    localparam int MID_SCALE  = 32768;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [2:0] stall_channel;
    } t_emit;

    logic [7:0]  stall_limit;
    logic [7:0]  exempt;
    logic [7:0]  payload [CHANNELS][PAY_LEN];
    int          fill [CHANNELS];
    logic [31:0] last_seen [CHANNELS];
    t_emit       emit_q[$];
    int          err_n = 0;

    task automatic flag_error(input string what);
        if (err_n < MAX_PRINTS)
            $display("[%0t] frame checker: %s", $time, what);
        err_n++;
    endtask

    // scale by 1229/1024, move to unsigned and keep the top byte, clamped
    function automatic logic [7:0] sample_to_byte(input logic signed [15:0] s);
        int scaled;
        int top;
        scaled = (int'(s) * GAIN) >>> 10;
        top    = (scaled + MID_SCALE) >>> 8;
        if (top > 255)
            return 8'hFF;
        if (top < 0)
            return 8'h00;
        return top[7:0];
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        t_emit e;
        e.kind          = KIND_BYTE;
        e.frame_byte    = b;
        e.last_byte     = is_last;
        e.stall_channel = 3'd0;
        emit_q.push_back(e);
    endtask

    task automatic packetize_item(input logic act, input logic [2:0] ch,
                                  input logic signed [15:0] s, input logic [31:0] now);
        t_emit       e;
        logic [31:0] elapsed;
        if (int'(ch) < CHANNELS) begin
            if (act == ACT_SAMPLE) begin
                payload[ch][fill[ch]] = sample_to_byte(s);
                fill[ch]++;
                last_seen[ch] = now;
                if (fill[ch] >= PAY_LEN) begin
                    queue_byte(HDR_SYNC0, 1'b0);
                    queue_byte(HDR_SYNC1, 1'b0);
                    queue_byte(HDR_SYNC2, 1'b0);
                    queue_byte(HDR_SYNC3, 1'b0);
                    queue_byte({5'd0, ch} + 8'd1, 1'b0);
                    for (int i = 0; i < PAY_LEN; i++)
                        queue_byte(payload[ch][i], i == PAY_LEN - 1);
                    fill[ch] = 0;
                end
            end else begin
                // a clock running behind the last sample counts as no time elapsed
                elapsed = (now >= last_seen[ch]) ? now - last_seen[ch] : 32'd0;
                if (!exempt[ch] && elapsed > {24'd0, stall_limit}) begin
                    e.kind          = KIND_ALERT;
                    e.frame_byte    = 8'd0;
                    e.last_byte     = 1'b0;
                    e.stall_channel = ch;
                    emit_q.push_back(e);
                end
            end
        end
    endtask

    task automatic check_result();
        t_emit got;
        t_emit want;
        got.kind          = i_res.kind;
        got.frame_byte    = i_res.frame_byte;
        got.last_byte     = i_res.last_byte;
        got.stall_channel = i_res.stall_channel;
        if (emit_q.size() == 0) begin
            flag_error($sformatf("unexpected transfer kind=%0d byte=%0d last=%0d ch=%0d",
                                 got.kind, got.frame_byte, got.last_byte,
                                 got.stall_channel));
        end else begin
            want = emit_q.pop_front();
            if (got.kind !== want.kind)
                flag_error($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.frame_byte !== want.frame_byte)
                flag_error($sformatf("frame_byte %0d, want %0d",
                                     got.frame_byte, want.frame_byte));
            if (got.last_byte !== want.last_byte)
                flag_error($sformatf("last_byte %0d, want %0d",
                                     got.last_byte, want.last_byte));
            if (got.stall_channel !== want.stall_channel)
                flag_error($sformatf("stall_channel %0d, want %0d",
                                     got.stall_channel, want.stall_channel));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_limit = RST_STALL_LIMIT;
            exempt      = RST_EXEMPT_MASK;
            for (int c = 0; c < CHANNELS; c++) begin
                fill[c]      = 0;
                last_seen[c] = 32'd0;
            end
            emit_q.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_STALL_LIMIT)
                    stall_limit = i_cfg.data;
                else if (i_cfg.index == REG_EXEMPT_MASK)
                    exempt = i_cfg.data;
            end
            if (i_smp.valid && i_smp.ready)
                packetize_item(i_smp.action, i_smp.channel, i_smp.sample,
                               i_smp.now_seconds);
        end
        o_pending   <= emit_q.size();
        o_err_count <= err_n;
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import aamp_pkg::*;
    import aamp_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int POLL_SETTLE  = 8;
    localparam int END_SETTLE   = 150;
    localparam int RX_HOLD_LEN  = 400;
    localparam int BURST_ITEMS  = 90;
    localparam logic [7:0] REG_UNUSED_LO = 8'd2;
    localparam logic [7:0] REG_UNUSED_HI = 8'hFF;

    logic        i_clk;
    logic        i_rst_n;
    int          err_count;
    int          pending_n;
    int          cycle_cnt;
    int          rx_hold_req;
    bit          tx_idle_on;
    bit          rx_idle_on;
    logic [31:0] clock_s;

    aamp_smp_if smp();
    aamp_res_if res();
    aamp_cfg_if cfg();

    audio_sample_am_packetizer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    aamp_frame_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp),
        .i_res       (res),
        .i_cfg       (cfg),
        .o_err_count (err_count),
        .o_pending   (pending_n)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d transfers outstanding", cycle_cnt, pending_n);
        $display("** audio_sample_am_packetizer_core: FAILED **");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                res.ready <= 1'b0;
                hold_left--;
            end else begin
                res.ready <= !(rx_idle_on && $urandom_range(99) < 34);
            end
        end
    end

    task automatic send_item(input t_action act, input logic [2:0] ch,
                             input logic signed [15:0] s, input logic [31:0] now);
        while (tx_idle_on && $urandom_range(99) < 34) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid       <= 1'b1;
        smp.action      <= act;
        smp.channel     <= ch;
        smp.sample      <= s;
        smp.now_seconds <= now;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    task automatic write_pair(input logic [7:0] idx0, input logic [7:0] val0,
                              input logic [7:0] idx1, input logic [7:0] val1);
        cfg.valid <= 1'b1;
        cfg.index <= idx0;
        cfg.data  <= val0;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.index <= idx1;
        cfg.data  <= val1;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // drop valid, let every predicted transfer arrive, then cover a poll in flight
    task automatic wait_idle();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_n != 0)
            @(posedge i_clk);
        repeat (POLL_SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return 16'($urandom);
        if (k < 78)
            return 16'($urandom_range(26000, 32767));
        if (k < 86)
            return -16'sd1 - 16'($urandom_range(26000, 32767));
        return 16'($urandom_range(0, 600)) - 16'sd300;
    endfunction

    // mostly a forward-running clock with samples on one busy channel
    task automatic run_random(input int n_items, input logic [2:0] busy_ch);
        logic [2:0]  ch;
        logic [31:0] now;
        int          k;
        for (int i = 0; i < n_items; i++) begin
            ch = ($urandom_range(99) < 75) ? busy_ch : 3'($urandom_range(7));
            k  = $urandom_range(99);
            if (k < 85) begin
                clock_s += $urandom_range(3);
                now = clock_s;
            end else if (k < 92) begin
                clock_s += $urandom_range(400);
                now = clock_s;
            end else if (k < 96) begin
                now = clock_s - $urandom_range(1, 20);
            end else begin
                now = $urandom;
            end
            if ($urandom_range(99) < 72)
                send_item(ACT_SAMPLE, ch, pick_sample(), now);
            else
                send_item(ACT_POLL, ch, 16'($urandom), now);
        end
    endtask

    initial begin
        smp.valid       = 1'b0;
        smp.action      = ACT_SAMPLE;
        smp.channel     = 3'd0;
        smp.sample      = 16'sd0;
        smp.now_seconds = 32'd0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_STALL_LIMIT;
        cfg.data        = 8'd0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_req     = 0;
        clock_s         = 32'd200;
        i_rst_n         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unmapped indexes must leave the reset values alone
        write_pair(REG_UNUSED_LO, 8'h55, REG_UNUSED_HI, 8'hAA);

        send_item(ACT_POLL,   3'd0, 16'sd0,      32'd0);
        send_item(ACT_POLL,   3'd1, 16'sd0,      32'd10);
        send_item(ACT_POLL,   3'd1, 16'sd0,      32'd11);
        send_item(ACT_POLL,   3'd1, -16'sd1,     32'd11);
        send_item(ACT_SAMPLE, 3'd3, -16'sd32768, 32'd100);
        send_item(ACT_SAMPLE, 3'd3, 16'sd32767,  32'd100);
        send_item(ACT_SAMPLE, 3'd3, 16'sd0,      32'd100);
        send_item(ACT_SAMPLE, 3'd3, -16'sd1,     32'd100);
        send_item(ACT_SAMPLE, 3'd3, 16'sd1,      32'd100);
        send_item(ACT_SAMPLE, 3'd3, 16'sd27306,  32'd100);
        send_item(ACT_SAMPLE, 3'd3, -16'sd27307, 32'd100);
        send_item(ACT_POLL,   3'd3, 16'sd0,      32'd99);
        send_item(ACT_POLL,   3'd3, 16'sd0,      32'd110);
        send_item(ACT_POLL,   3'd3, 16'sd0,      32'd111);
        send_item(ACT_SAMPLE, 3'd7, 16'sh5A5A,   32'hFFFF_FFFF);
        send_item(ACT_POLL,   3'd7, 16'sd0,      32'd5);
        send_item(ACT_POLL,   3'd6, 16'sd0,      32'hFFFF_FFFF);
        send_item(ACT_SAMPLE, 3'd4, -16'sh5A5B,  32'd7);
        send_item(ACT_SAMPLE, 3'd5, 16'sd300,    32'd8);
        wait_idle();

        // everything exempt, zero limit
        write_pair(REG_STALL_LIMIT, 8'd0, REG_EXEMPT_MASK, 8'hFF);
        send_item(ACT_POLL, 3'd6, 16'sd0, 32'd12345);
        send_item(ACT_POLL, 3'd0, 16'sd0, 32'd1);
        wait_idle();

        write_pair(REG_STALL_LIMIT, 8'd0, REG_EXEMPT_MASK, 8'h5A);
        send_item(ACT_POLL, 3'd1, 16'sd0, 32'd50);
        send_item(ACT_POLL, 3'd0, 16'sd0, 32'd1);
        send_item(ACT_POLL, 3'd0, 16'sd0, 32'd0);
        wait_idle();

        // hold the result side while a long run of samples fills one channel
        write_pair(REG_STALL_LIMIT, 8'd255, REG_EXEMPT_MASK, 8'h00);
        rx_hold_req = RX_HOLD_LEN;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            clock_s += $urandom_range(2);
            send_item(ACT_SAMPLE, 3'd2, pick_sample(), clock_s);
        end
        wait_idle();

        write_pair(REG_STALL_LIMIT, 8'($urandom), REG_EXEMPT_MASK, 8'($urandom));
        run_random(60, 3'($urandom_range(7)));
        wait_idle();

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_pair(REG_STALL_LIMIT, 8'd10, REG_EXEMPT_MASK, 8'h00);
        run_random(60, 3'($urandom_range(7)));
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        write_pair(REG_STALL_LIMIT, 8'd3, REG_EXEMPT_MASK, 8'h81);
        run_random(40, 3'd2);
        wait_idle();

        repeat (END_SETTLE) @(posedge i_clk);
        if (err_count == 0)
            $display("** audio_sample_am_packetizer_core: PASSED **");
        else
            $display("** audio_sample_am_packetizer_core: FAILED **");
        $finish;
    end

endmodule

// ===== audio_sample_am_packetizer_core.f =====
rtl/aamp_pkg.sv
rtl/aamp_if.sv
rtl/aamp_ram.sv
rtl/aamp_ctrl.sv
rtl/aamp_dpath.sv
rtl/audio_sample_am_packetizer_core.sv
dv/aamp_tb_pkg.sv
dv/aamp_frame_checker.sv
dv/testbench.sv
